// ===== hdl/rmq_pkg.sv =====
`default_nettype none
package rmq_pkg;

    // default number format, signed Q2.14
    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    // block scaling puts the largest magnitude's top bit here
    localparam int TOP_POS = 29;
    localparam int MAG_W   = TOP_POS + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ROOT_W  = SUM_W / 2;

    localparam int LANES = 4;

endpackage
`default_nettype wire

// ===== hdl/rotation_matrix_to_quaternion_unit.sv =====
`default_nettype none
// rotation matrix to unit quaternion, fully pipelined
//
// input channel: nine matrix entries i_m00..i_m22, signed fixed point, one beat
// per matrix, taken when i_valid is high and o_stall is low
// output channel: o_qx, o_qy, o_qz, o_qw and o_bad_input, one beat per matrix,
// taken when o_valid is high and i_stall is low
// throughput: one matrix per cycle while no output beat is stalled, no
// dependence between beats; the depth is set by the square root, one root bit
// per stage, and the divider, one quotient bit per stage
// a non-positive root argument gives zeros with o_bad_input set
// reset (synchronous, active low) empties the pipeline, no output beat follows
// while the receiver stalls a valid beat, the whole pipeline holds and o_stall
// rises, so nothing is lost or repeated
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic signed [DATA_WIDTH-1:0] i_m00,
    input  wire logic signed [DATA_WIDTH-1:0] i_m01,
    input  wire logic signed [DATA_WIDTH-1:0] i_m02,
    input  wire logic signed [DATA_WIDTH-1:0] i_m10,
    input  wire logic signed [DATA_WIDTH-1:0] i_m11,
    input  wire logic signed [DATA_WIDTH-1:0] i_m12,
    input  wire logic signed [DATA_WIDTH-1:0] i_m20,
    input  wire logic signed [DATA_WIDTH-1:0] i_m21,
    input  wire logic signed [DATA_WIDTH-1:0] i_m22,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0]      o_qx,
    output logic signed [DATA_WIDTH-1:0]      o_qy,
    output logic signed [DATA_WIDTH-1:0]      o_qz,
    output logic signed [DATA_WIDTH-1:0]      o_qw,
    output logic                              o_bad_input
);

    // width that holds sums of three entries plus one
    localparam int EW = ((DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1) + 3;
    localparam int PW = $clog2(EW);
    localparam int SHW = EW + TOP_POS;
    // numerator of the division and quotient width (quotient never exceeds one)
    localparam int NW = MAG_W + FRAC_BITS + 1;
    localparam int QW = FRAC_BITS + 2;
    localparam int LW = ((QW > DATA_WIDTH) ? QW : DATA_WIDTH) + 1;
    localparam int SQ_SIDE = LANES * MAG_W + LANES + 1;
    localparam int DV_SIDE = LANES + 1;
    localparam logic signed [EW-1:0] ONE = EW'(1) << FRAC_BITS;

    // single advance for every stage: hold everything while the output beat waits
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // ---- stage 1: branch choice and unnormalized vector
    logic signed [EW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [EW-1:0] tr, arg;
    logic signed [EW-1:0] n_s1_v [LANES];
    logic signed [EW-1:0] r_s1_v [LANES];
    logic                 r_s1_arg_pos;
    logic                 r_s1_vld;

    assign a00 = EW'(i_m00);
    assign a01 = EW'(i_m01);
    assign a02 = EW'(i_m02);
    assign a10 = EW'(i_m10);
    assign a11 = EW'(i_m11);
    assign a12 = EW'(i_m12);
    assign a20 = EW'(i_m20);
    assign a21 = EW'(i_m21);
    assign a22 = EW'(i_m22);
    assign tr  = a00 + a11 + a22;

    always_comb begin
        if (tr > 0) begin
            // trace branch, w is the big one
            arg       = tr + ONE;
            n_s1_v[0] = a12 - a21;
            n_s1_v[1] = a20 - a02;
            n_s1_v[2] = a01 - a10;
            n_s1_v[3] = arg;
        end else if (a00 > a11 && a00 > a22) begin
            arg       = ONE + a00 - a11 - a22;
            n_s1_v[0] = arg;
            n_s1_v[1] = a10 + a01;
            n_s1_v[2] = a20 + a02;
            n_s1_v[3] = a12 - a21;
        end else if (a11 > a22) begin
            arg       = ONE + a11 - a00 - a22;
            n_s1_v[0] = a01 + a10;
            n_s1_v[1] = arg;
            n_s1_v[2] = a12 + a21;
            n_s1_v[3] = a20 - a02;
        end else begin
            arg       = ONE + a22 - a00 - a11;
            n_s1_v[0] = a20 + a02;
            n_s1_v[1] = a21 + a12;
            n_s1_v[2] = arg;
            n_s1_v[3] = a01 - a10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_valid;
        end
        if (en) begin
            r_s1_v       <= n_s1_v;
            r_s1_arg_pos <= (arg > 0);
        end
    end

    // ---- stage 2: sign and magnitude; or of magnitudes shares the max's top bit
    logic [EW-1:0] n_s2_mag [LANES];
    logic [EW-1:0] n_s2_or;
    logic [EW-1:0] r_s2_mag [LANES];
    logic [LANES-1:0] r_s2_neg;
    logic [EW-1:0] r_s2_or;
    logic          r_s2_bad;
    logic          r_s2_vld;

    always_comb begin
        n_s2_or = '0;
        for (int l = 0; l < LANES; l++) begin
            n_s2_mag[l] = r_s1_v[l][EW-1] ? EW'(-r_s1_v[l]) : EW'(r_s1_v[l]);
            n_s2_or     = n_s2_or | n_s2_mag[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
        if (en) begin
            r_s2_mag <= n_s2_mag;
            r_s2_or  <= n_s2_or;
            r_s2_bad <= !r_s1_arg_pos || (n_s2_or == '0);
            for (int l = 0; l < LANES; l++) begin
                r_s2_neg[l] <= r_s1_v[l][EW-1];
            end
        end
    end

    // ---- stage 3: top set bit position
    logic [PW-1:0] n_s3_p;
    logic [PW-1:0] r_s3_p;
    logic [EW-1:0] r_s3_mag [LANES];
    logic [LANES-1:0] r_s3_neg;
    logic          r_s3_bad;
    logic          r_s3_vld;

    always_comb begin
        n_s3_p = '0;
        for (int b = 0; b < EW; b++) begin
            if (r_s2_or[b]) begin
                n_s3_p = PW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= r_s2_vld;
        end
        if (en) begin
            r_s3_p   <= n_s3_p;
            r_s3_mag <= r_s2_mag;
            r_s3_neg <= r_s2_neg;
            r_s3_bad <= r_s2_bad;
        end
    end

    // ---- stage 4: block scaling, mag * 2^(TOP_POS - p), truncating
    logic [SHW-1:0]   sh [LANES];
    logic [MAG_W-1:0] r_s4_mag [LANES];
    logic [LANES-1:0] r_s4_neg;
    logic             r_s4_bad;
    logic             r_s4_vld;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            sh[l] = {r_s3_mag[l], {TOP_POS{1'b0}}} >> r_s3_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (en) begin
            r_s4_vld <= r_s3_vld;
        end
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_s4_mag[l] <= sh[l][MAG_W-1:0];
            end
            r_s4_neg <= r_s3_neg;
            r_s4_bad <= r_s3_bad;
        end
    end

    // ---- stage 5: squares
    logic [SQ_W-1:0]  r_s5_sq  [LANES];
    logic [MAG_W-1:0] r_s5_mag [LANES];
    logic [LANES-1:0] r_s5_neg;
    logic             r_s5_bad;
    logic             r_s5_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s5_vld <= r_s4_vld;
        end
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_s5_sq[l] <= r_s4_mag[l] * r_s4_mag[l];
            end
            r_s5_mag <= r_s4_mag;
            r_s5_neg <= r_s4_neg;
            r_s5_bad <= r_s4_bad;
        end
    end

    // ---- stage 6: sum of squares
    logic [SUM_W-1:0] r_s6_sum;
    logic [SQ_SIDE-1:0] r_s6_side;
    logic             r_s6_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= r_s5_vld;
        end
        if (en) begin
            r_s6_sum  <= SUM_W'(r_s5_sq[0]) + SUM_W'(r_s5_sq[1])
                       + SUM_W'(r_s5_sq[2]) + SUM_W'(r_s5_sq[3]);
            r_s6_side <= {r_s5_mag[3], r_s5_mag[2], r_s5_mag[1], r_s5_mag[0],
                          r_s5_neg, r_s5_bad};
        end
    end

    // ---- norm
    logic               sq_vld;
    logic [ROOT_W-1:0]  sq_root;
    logic [SQ_SIDE-1:0] sq_side;

    rmq_sqrt #(
        .SW (SQ_SIDE)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s6_vld),
        .i_rad   (r_s6_sum),
        .i_side  (r_s6_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---- stage 7: rounded numerators
    logic [NW-1:0]      r_s7_num [LANES];
    logic [ROOT_W-1:0]  r_s7_den;
    logic [DV_SIDE-1:0] r_s7_side;
    logic               r_s7_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (en) begin
            r_s7_vld <= sq_vld;
        end
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                r_s7_num[l] <= NW'({sq_side[DV_SIDE + l*MAG_W +: MAG_W],
                                    {FRAC_BITS{1'b0}}}) + NW'(sq_root >> 1);
            end
            r_s7_den  <= sq_root;
            r_s7_side <= sq_side[DV_SIDE-1:0];
        end
    end

    // ---- division by the norm
    logic               dv_vld;
    logic [QW-1:0]      dv_quo [LANES];
    logic [DV_SIDE-1:0] dv_side;

    rmq_div #(
        .NW (NW),
        .QW (QW),
        .SW (DV_SIDE)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s7_vld),
        .i_num   (r_s7_num),
        .i_den   (r_s7_den),
        .i_side  (r_s7_side),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // ---- output stage: saturate, apply sign, zero on bad input
    logic [LW-1:0]         qe   [LANES];
    logic [LW-1:0]         lim  [LANES];
    logic [LW-1:0]         qs   [LANES];
    logic [DATA_WIDTH-1:0] n_q  [LANES];
    logic [DATA_WIDTH-1:0] r_q  [LANES];
    logic                  r_bad;
    logic                  r_vld;
    logic                  dv_bad;

    assign dv_bad = dv_side[0];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            qe[l]  = LW'(dv_quo[l]);
            lim[l] = dv_side[1 + l] ? (LW'(1) << (DATA_WIDTH - 1))
                                    : ((LW'(1) << (DATA_WIDTH - 1)) - LW'(1));
            qs[l]  = (qe[l] > lim[l]) ? lim[l] : qe[l];
            if (dv_bad) begin
                n_q[l] = '0;
            end else if (dv_side[1 + l]) begin
                n_q[l] = DATA_WIDTH'(-qs[l]);
            end else begin
                n_q[l] = qs[l][DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= dv_vld;
        end
        if (en) begin
            r_q   <= n_q;
            r_bad <= dv_bad;
        end
    end

    assign o_valid     = r_vld;
    assign o_qx        = r_q[0];
    assign o_qy        = r_q[1];
    assign o_qz        = r_q[2];
    assign o_qw        = r_q[3];
    assign o_bad_input = r_bad;

    // ---- checks
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_input |-> o_qx == '0 && o_qy == '0 && o_qz == '0 && o_qw == '0)
        else $error("bad input beat carries a nonzero component");

    a_good_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_input |-> o_qx != '0 || o_qy != '0 || o_qz != '0 || o_qw != '0)
        else $error("normalized quaternion is all zero");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input held off with no waiting output beat");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_qx) && $stable(o_bad_input))
        else $error("pipeline moved during output stall");

endmodule
`default_nettype wire

// ===== hdl/rmq_sqrt.sv =====
`default_nettype none
module rmq_sqrt
    import rmq_pkg::*;
#(
    parameter int SW = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [SUM_W-1:0]  i_rad,
    input  wire logic [SW-1:0]     i_side,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root,
    output logic [SW-1:0]          o_side
);

    // one result bit per stage, radicand remainder and partial root travel along
    logic [SUM_W-1:0] r_x    [ROOT_W];
    logic [SUM_W-1:0] r_res  [ROOT_W];
    logic [SW-1:0]    r_side [ROOT_W];
    logic             r_vld  [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (ROOT_W - 1 - s));
        logic [SUM_W-1:0] x_in;
        logic [SUM_W-1:0] res_in;
        logic [SW-1:0]    side_in;
        logic             vld_in;
        logic [SUM_W-1:0] t;
        logic [SUM_W-1:0] n_x;
        logic [SUM_W-1:0] n_res;

        if (s == 0) begin : g_first
            assign x_in    = i_rad;
            assign res_in  = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            assign x_in    = r_x[s-1];
            assign res_in  = r_res[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        always_comb begin
            t = res_in + BIT;
            if (x_in >= t) begin
                n_x   = x_in - t;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_x   = x_in;
                n_res = res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
            if (i_en) begin
                r_x[s]    <= n_x;
                r_res[s]  <= n_res;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1][ROOT_W-1:0];
    assign o_side  = r_side[ROOT_W-1];

endmodule
`default_nettype wire

// ===== hdl/rmq_div.sv =====
`default_nettype none
module rmq_div
    import rmq_pkg::*;
#(
    parameter int NW = 45,
    parameter int QW = 16,
    parameter int SW = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire logic [NW-1:0]      i_num [LANES],
    input  wire logic [ROOT_W-1:0]  i_den,
    input  wire logic [SW-1:0]      i_side,
    output logic                    o_valid,
    output logic [QW-1:0]           o_quo [LANES],
    output logic [SW-1:0]           o_side
);

    localparam int CW = ROOT_W + QW;

    // restoring division, one quotient bit per stage, four lanes share the divisor
    logic [CW-1:0]     r_rem  [QW][LANES];
    logic [QW-1:0]     r_quo  [QW][LANES];
    logic [ROOT_W-1:0] r_den  [QW];
    logic [SW-1:0]     r_side [QW];
    logic              r_vld  [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;
        logic [CW-1:0]     rem_in  [LANES];
        logic [QW-1:0]     quo_in  [LANES];
        logic [ROOT_W-1:0] den_in;
        logic [SW-1:0]     side_in;
        logic              vld_in;
        logic [CW-1:0]     d;
        logic [CW-1:0]     n_rem   [LANES];
        logic [QW-1:0]     n_quo   [LANES];

        if (s == 0) begin : g_first
            for (genvar l = 0; l < LANES; l++) begin : g_l
                assign rem_in[l] = CW'(i_num[l]);
                assign quo_in[l] = '0;
            end
            assign den_in  = i_den;
            assign side_in = i_side;
            assign vld_in  = i_valid;
        end else begin : g_next
            for (genvar l = 0; l < LANES; l++) begin : g_l
                assign rem_in[l] = r_rem[s-1][l];
                assign quo_in[l] = r_quo[s-1][l];
            end
            assign den_in  = r_den[s-1];
            assign side_in = r_side[s-1];
            assign vld_in  = r_vld[s-1];
        end

        assign d = CW'(den_in) << B;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                n_quo[l] = quo_in[l];
                if (rem_in[l] >= d) begin
                    n_rem[l]    = rem_in[l] - d;
                    n_quo[l][B] = 1'b1;
                end else begin
                    n_rem[l] = rem_in[l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
            if (i_en) begin
                for (int l = 0; l < LANES; l++) begin
                    r_rem[s][l] <= n_rem[l];
                    r_quo[s][l] <= n_quo[l];
                end
                r_den[s]  <= den_in;
                r_side[s] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_side  = r_side[QW-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign o_quo[l] = r_quo[QW-1][l];
    end

endmodule
`default_nettype wire

// ===== verif/tb_rotation_matrix_to_quaternion_unit.sv =====
`default_nettype none
module tb_rotation_matrix_to_quaternion_unit;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int LATENCY = 8 + 31 + (FB + 2);
    localparam int N_RANDOM = 1080;

    typedef logic signed [DW-1:0] entry_t;

    // one matrix beat, row-major
    typedef struct {
        entry_t m [9];
    } matrix_t;

    // one quaternion beat
    typedef struct {
        entry_t q [4];
        logic   bad;
    } quat_t;

    // directed row: matrix plus optional hand-typed answer
    typedef struct {
        matrix_t mat;
        logic    typed;
        quat_t   ans;
    } row_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    entry_t i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22;
    logic   o_valid;
    logic   i_stall;
    entry_t o_qx, o_qy, o_qz, o_qw;
    logic   o_bad_input;

    rotation_matrix_to_quaternion_unit #(
        .DATA_WIDTH(DW),
        .FRAC_BITS (FB)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_m00      (i_m00),
        .i_m01      (i_m01),
        .i_m02      (i_m02),
        .i_m10      (i_m10),
        .i_m11      (i_m11),
        .i_m12      (i_m12),
        .i_m20      (i_m20),
        .i_m21      (i_m21),
        .i_m22      (i_m22),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_qx       (o_qx),
        .o_qy       (o_qy),
        .o_qz       (o_qz),
        .o_qw       (o_qw),
        .o_bad_input(o_bad_input)
    );

    // quaternions still owed by the block, oldest first
    quat_t owed_quats [$];
    int    n_errors;
    int    n_sent;
    int    n_got;
    int    n_bad_seen;
    int    branch_hits [4];

    // idling odds in percent, changed by phase
    int send_idle_pct;
    int recv_stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well past the slowest legal run
    initial begin
        #(20_000_000);
        $display("timeout waiting for quaternion beats");
        $display("rotation_matrix_to_quaternion_unit verification failed");
        $finish;
    end

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // shepperd conversion with block-scaled normalization
    function automatic quat_t shepperd_quat(input matrix_t mt, output int branch);
        quat_t           res;
        longint          a [9];
        longint          tr, arg, one;
        longint          v [4];
        longint unsigned mag [4];
        logic            neg [4];
        longint unsigned mx, sum, nrm, quo, lim;
        int              p;
        for (int k = 0; k < 9; k++) a[k] = mt.m[k];
        one = longint'(1) << FB;
        tr  = a[0] + a[4] + a[8];
        if (tr > 0) begin
            branch = 0;
            arg = tr + one;
            v[0] = a[5] - a[7]; v[1] = a[6] - a[2]; v[2] = a[1] - a[3]; v[3] = arg;
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            branch = 1;
            arg = one + a[0] - a[4] - a[8];
            v[0] = arg; v[1] = a[3] + a[1]; v[2] = a[6] + a[2]; v[3] = a[5] - a[7];
        end else if (a[4] > a[8]) begin
            branch = 2;
            arg = one + a[4] - a[0] - a[8];
            v[0] = a[1] + a[3]; v[1] = arg; v[2] = a[5] + a[7]; v[3] = a[6] - a[2];
        end else begin
            branch = 3;
            arg = one + a[8] - a[0] - a[4];
            v[0] = a[6] + a[2]; v[1] = a[7] + a[5]; v[2] = arg; v[3] = a[1] - a[3];
        end
        mx = 0;
        for (int k = 0; k < 4; k++) begin
            neg[k] = v[k] < 0;
            mag[k] = neg[k] ? longint'(-v[k]) : v[k];
            if (mag[k] > mx) mx = mag[k];
        end
        res.bad = 1'b0;
        if (arg <= 0 || mx == 0) begin
            for (int k = 0; k < 4; k++) res.q[k] = '0;
            res.bad = 1'b1;
            return res;
        end
        p = -1;
        while (mx != 0) begin
            mx >>= 1;
            p++;
        end
        sum = 0;
        for (int k = 0; k < 4; k++) begin
            if (p > TOP_POS) mag[k] >>= (p - TOP_POS);
            else             mag[k] <<= (TOP_POS - p);
            sum += mag[k] * mag[k];
        end
        nrm = floor_sqrt(sum);
        for (int k = 0; k < 4; k++) begin
            quo = ((mag[k] << FB) + (nrm >> 1)) / nrm;
            lim = neg[k] ? (64'd1 << (DW - 1)) : ((64'd1 << (DW - 1)) - 1);
            if (quo > lim) quo = lim;
            res.q[k] = neg[k] ? entry_t'(-quo) : entry_t'(quo);
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch beat %0d %s: got %0d expected %0d", n_got, what, got, want);
        n_errors++;
    endtask

    // drive one matrix and hold it until the block takes it
    task automatic send_matrix(input matrix_t mt, input logic typed, input quat_t ans);
        quat_t pred;
        int    br;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} <=
            {mt.m[0], mt.m[1], mt.m[2], mt.m[3], mt.m[4], mt.m[5], mt.m[6], mt.m[7], mt.m[8]};
        pred = shepperd_quat(mt, br);
        do @(posedge i_clk); while (o_stall);
        owed_quats.push_back(typed ? ans : pred);
        branch_hits[br]++;
        n_sent++;
    endtask

    // receiver: random stall, compare each taken beat
    always @(posedge i_clk) begin
        quat_t want;
        entry_t got [4];
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_qx, o_qy, o_qz, o_qw};
                if (owed_quats.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = owed_quats.pop_front();
                    for (int k = 0; k < 4; k++)
                        if (got[k] !== want.q[k])
                            report_mismatch($sformatf("q[%0d]", k), got[k], want.q[k]);
                    if (o_bad_input !== want.bad)
                        report_mismatch("bad_input", o_bad_input, want.bad);
                    if (o_bad_input === 1'b1) n_bad_seen++;
                end
                n_got++;
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic matrix_t mk(input int e0, e1, e2, e3, e4, e5, e6, e7, e8);
        matrix_t mt;
        mt.m = '{entry_t'(e0), entry_t'(e1), entry_t'(e2), entry_t'(e3), entry_t'(e4),
                 entry_t'(e5), entry_t'(e6), entry_t'(e7), entry_t'(e8)};
        return mt;
    endfunction

    function automatic row_t free_row(input matrix_t mt);
        row_t r;
        r.mat   = mt;
        r.typed = 1'b0;
        r.ans   = '{q: '{default: '0}, bad: 1'b0};
        return r;
    endfunction

    function automatic row_t typed_row(input matrix_t mt, input int x, y, z, w, input logic b);
        row_t r;
        r.mat   = mt;
        r.typed = 1'b1;
        r.ans.q = '{entry_t'(x), entry_t'(y), entry_t'(z), entry_t'(w)};
        r.ans.bad = b;
        return r;
    endfunction

    // near-rotation matrix from a random quaternion, plus a little noise
    function automatic matrix_t rotation_like();
        matrix_t mt;
        real     qa, qb, qc, qd, nn, s;
        real     r [9];
        qa = $itor($urandom_range(2000)) - 1000.0;
        qb = $itor($urandom_range(2000)) - 1000.0;
        qc = $itor($urandom_range(2000)) - 1000.0;
        qd = $itor($urandom_range(2000)) - 1000.0;
        nn = qa*qa + qb*qb + qc*qc + qd*qd + 1.0;
        s  = 2.0 / nn;
        // qa,qb,qc vector part, qd scalar
        r[0] = 1.0 - s*(qb*qb + qc*qc); r[1] = s*(qa*qb - qc*qd); r[2] = s*(qa*qc + qb*qd);
        r[3] = s*(qa*qb + qc*qd); r[4] = 1.0 - s*(qa*qa + qc*qc); r[5] = s*(qb*qc - qa*qd);
        r[6] = s*(qa*qc - qb*qd); r[7] = s*(qb*qc + qa*qd); r[8] = 1.0 - s*(qa*qa + qb*qb);
        for (int k = 0; k < 9; k++)
            mt.m[k] = entry_t'($rtoi(r[k] * 16384.0) + int'($urandom_range(8)) - 4);
        return mt;
    endfunction

    initial begin
        row_t    rows [$];
        matrix_t mt;
        int      pick;
        n_errors = 0; n_sent = 0; n_got = 0; n_bad_seen = 0;
        branch_hits = '{default: 0};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        {i_m00, i_m01, i_m02, i_m10, i_m11, i_m12, i_m20, i_m21, i_m22} <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity and the half-turns about each axis, answers read off directly
        rows.push_back(typed_row(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 0, 0, 0, 16384, 0));
        rows.push_back(typed_row(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 16384, 0, 0, 0, 0));
        rows.push_back(typed_row(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 0, 16384, 0, 0, 0));
        rows.push_back(typed_row(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 0, 0, 16384, 0, 0));
        // equal or zero diagonals fall through to the m22 branch, argument stays positive
        rows.push_back(typed_row(mk(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768), 0, 0, 16384, 0, 0));
        rows.push_back(typed_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 16384, 0, 0));
        rows.push_back(typed_row(mk(-16384, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 16384, 0, 0));
        // ties on the diagonal fall through to the later branch
        rows.push_back(free_row(mk(-100, 5, 7, 9, -100, 11, 13, 17, -100)));
        rows.push_back(free_row(mk(-50, 5, 7, 9, -50, 11, 13, 17, -200)));
        rows.push_back(free_row(mk(-50, 5, 7, 9, -200, 11, 13, 17, -50)));
        // field extremes, both polarities of every bit; then tiny +-1 entries and a 45 degree turn about z
        rows.push_back(free_row(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767)));
        rows.push_back(free_row(mk(32767, -32768, -32768, -32768, 32767, -32768,
                                   -32768, -32768, 32767)));
        rows.push_back(free_row(mk(32767, 32767, -32768, -32768, -32768, 32767,
                                   32767, -32768, -32768)));
        rows.push_back(free_row(mk(-32768, 32767, 32767, -32768, -32768, -32768,
                                   -32768, 32767, -32768)));
        rows.push_back(free_row(mk(-32768, -32768, 32767, 32767, -32768, 32767,
                                   -32768, -32768, -32768)));
        rows.push_back(free_row(mk(1, -1, 1, -1, 1, -1, 1, -1, 1)));
        rows.push_back(free_row(mk(11585, -11585, 0, 11585, 11585, 0, 0, 0, 16384)));

        foreach (rows[k]) send_matrix(rows[k].mat, rows[k].typed, rows[k].ans);

        // random part: mostly rotation-like matrices, the rest raw noise,
        // in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 18 : (ph == 1) ? 74 : 0;
            recv_stall_pct = (ph == 0) ? 74 : (ph == 1) ? 18 : 0;
            for (int k = 0; k < N_RANDOM / 3; k++) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    mt = rotation_like();
                end else begin
                    for (int e = 0; e < 9; e++) mt.m[e] = entry_t'($urandom);
                end
                send_matrix(mt, 1'b0, '{q: '{default: '0}, bad: 1'b0});
            end
        end
        i_valid <= 1'b0;

        while (owed_quats.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d matrices sent, %0d quaternions checked, %0d flagged bad",
                 n_sent, n_got, n_bad_seen);
        $display("branches taken: trace %0d, m00 %0d, m11 %0d, m22 %0d",
                 branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
        if (n_errors == 0 && owed_quats.size() == 0) begin
            $display("rotation_matrix_to_quaternion_unit verification clean");
        end else begin
            $display("rotation_matrix_to_quaternion_unit verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/rmq_pkg.sv
hdl/rmq_sqrt.sv
hdl/rmq_div.sv
hdl/rotation_matrix_to_quaternion_unit.sv
verif/tb_rotation_matrix_to_quaternion_unit.sv
